// ===== src/sddw_pkg.sv =====
// shared types and constants of the signed decimal digit writer
// used by the converter, the emitter and the top level

package sddw_pkg;

  localparam int VALUE_W       = 32;
  localparam int BCD_DIGITS    = 10;
  localparam int BCD_W         = 4 * BCD_DIGITS;
  localparam int POS_W         = 4;
  localparam int SPOS_W        = 6;
  localparam int DEC_W         = 3;
  localparam int SYM_W         = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam int SHIFT_CNT_W   = $clog2(VALUE_W);
  localparam int FIRST_POS_DEF = 1;
  localparam int LAST_POS_DEF  = 8;
  localparam logic [SYM_W-1:0] MINUS_CODE_RST = 8'd16;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             neg;
    logic [POS_W-1:0] units;
    logic [DEC_W-1:0] decs;
    logic             bad;
  } sddw_job_t;

  typedef struct packed {
    logic             write_valid;
    logic [POS_W-1:0] digit_position;
    logic [SYM_W-1:0] symbol;
    logic             status;
    logic             last;
  } sddw_res_t;

endpackage

// ===== src/signed_decimal_digit_writer_core.sv =====
// top level of the signed decimal digit writer: converter, emitter, minus code register
// depends on sddw_pkg, sddw_conv, sddw_emit
//
// channel | dir | transaction                   | payload
// in_     | in  | in_tvalid & in_tready         | in_tdata: value, units_position, decimals
// out_    | out | out_tvalid & out_tready       | out_tdata, out_tuser, out_tlast
// cfg_    | in  | cfg_valid & cfg_ready         | cfg_data: minus_code
//
// an item passes through the bit-serial bcd converter one value bit at a time;
// its results come from an output register, one per cycle while out_tready is high,
// 1 to 8 per item.
// the converter takes a new item once the previous one is handed off, while its emission overlaps;
// out_tready low holds the output register and, if the emitter is still busy at the next
// handoff, the converter and in_tready.
// a bad position skips conversion and gives its single result.
// rst_n clears control state and sets minus_code to 16.

module signed_decimal_digit_writer_core #(
  parameter int FIRST_POS = sddw_pkg::FIRST_POS_DEF,
  parameter int LAST_POS  = sddw_pkg::LAST_POS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], units_position[35:32], decimals[38:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // digit_position[3:0], symbol[11:4], status[12]
  output logic        out_tuser,  // write_valid
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // minus_code
);

  logic [sddw_pkg::SYM_W-1:0] minus_code_r;
  logic                       job_valid;
  logic                       job_ready;
  sddw_pkg::sddw_job_t        job;
  sddw_pkg::sddw_res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minus_code_r <= sddw_pkg::MINUS_CODE_RST;
    end else if (cfg_valid) begin
      minus_code_r <= cfg_data;
    end
  end

  sddw_conv #(
    .FIRST_POS(FIRST_POS),
    .LAST_POS (LAST_POS)
  ) u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_value (in_tdata[31:0]),
    .in_units (in_tdata[35:32]),
    .in_decs  (in_tdata[38:36]),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (job)
  );

  sddw_emit #(
    .FIRST_POS(FIRST_POS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .minus_code(minus_code_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {3'b000, res.status, res.symbol, res.digit_position};
  assign out_tuser = res.write_valid;
  assign out_tlast = res.last;

  a_nowrite_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[12])
    else $error("bad position result not a single failing transaction");

  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[12])
    else $error("status set before the last result");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && !out_tlast |-> out_tdata[11:4] <= 8'd9)
    else $error("non-final result is not a decimal digit");

endmodule

// ===== src/sddw_conv.sv =====
// bit-serial binary to bcd converter (shift and add-3), one bit per cycle
// depends on sddw_pkg

module sddw_conv #(
  parameter int FIRST_POS = sddw_pkg::FIRST_POS_DEF,
  parameter int LAST_POS  = sddw_pkg::LAST_POS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sddw_pkg::VALUE_W-1:0]   in_value,
  input  logic [sddw_pkg::POS_W-1:0]     in_units,
  input  logic [sddw_pkg::DEC_W-1:0]     in_decs,
  output logic                           job_valid,
  input  logic                           job_ready,
  output sddw_pkg::sddw_job_t            job
);

  localparam logic [1:0] CV_IDLE = 2'd0;
  localparam logic [1:0] CV_RUN  = 2'd1;
  localparam logic [1:0] CV_DONE = 2'd2;
  localparam logic [sddw_pkg::SHIFT_CNT_W-1:0] LAST_SHIFT =
    sddw_pkg::SHIFT_CNT_W'(sddw_pkg::VALUE_W - 1);
  localparam logic [sddw_pkg::POS_W-1:0] FIRST_U = sddw_pkg::POS_W'(FIRST_POS);
  localparam logic [sddw_pkg::POS_W-1:0] LAST_U  = sddw_pkg::POS_W'(LAST_POS);

  logic [1:0]                          state_r, state_nxt;
  logic [sddw_pkg::SHIFT_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [sddw_pkg::VALUE_W-1:0]        bin_r, bin_nxt;
  logic [sddw_pkg::BCD_W-1:0]          bcd_r, bcd_nxt;
  logic [sddw_pkg::BCD_W-1:0]          bcd_adj;
  logic                                neg_r, neg_nxt;
  logic [sddw_pkg::POS_W-1:0]          units_r, units_nxt;
  logic [sddw_pkg::DEC_W-1:0]          decs_r, decs_nxt;
  logic                                bad_r, bad_nxt;
  logic                                in_bad;

  assign in_ready  = (state_r == CV_IDLE);
  assign job_valid = (state_r == CV_DONE);
  assign in_bad    = (in_units < FIRST_U) || (in_units > LAST_U);

  always_comb begin
    for (int i = 0; i < sddw_pkg::BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    units_nxt = units_r;
    decs_nxt  = decs_r;
    bad_nxt   = bad_r;
    unique case (state_r)
      CV_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_value[sddw_pkg::VALUE_W-1];
          bin_nxt   = in_value[sddw_pkg::VALUE_W-1] ? (~in_value + 1'b1) : in_value;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          units_nxt = in_units;
          decs_nxt  = in_decs;
          bad_nxt   = in_bad;
          state_nxt = in_bad ? CV_DONE : CV_RUN;
        end
      end
      CV_RUN: begin
        bcd_nxt = {bcd_adj[sddw_pkg::BCD_W-2:0], bin_r[sddw_pkg::VALUE_W-1]};
        bin_nxt = {bin_r[sddw_pkg::VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_SHIFT) begin
          state_nxt = CV_DONE;
        end
      end
      CV_DONE: begin
        if (job_ready) begin
          state_nxt = CV_IDLE;
        end
      end
      default: state_nxt = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r   <= cnt_nxt;
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    neg_r   <= neg_nxt;
    units_r <= units_nxt;
    decs_r  <= decs_nxt;
    bad_r   <= bad_nxt;
  end

  assign job.bcd   = bcd_r;
  assign job.neg   = neg_r;
  assign job.units = units_r;
  assign job.decs  = decs_r;
  assign job.bad   = bad_r;

endmodule

// ===== src/sddw_emit.sv =====
// digit emitter: shifts out one bcd digit per result, places the minus sign, answers a bad position with one result
// depends on sddw_pkg

module sddw_emit #(
  parameter int FIRST_POS = sddw_pkg::FIRST_POS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  sddw_pkg::sddw_job_t          job,
  input  logic [sddw_pkg::SYM_W-1:0]   minus_code,
  output logic                         res_valid,
  input  logic                         res_ready,
  output sddw_pkg::sddw_res_t          res
);

  localparam logic [1:0] EM_IDLE  = 2'd0;
  localparam logic [1:0] EM_DIGIT = 2'd1;
  localparam logic [1:0] EM_MINUS = 2'd2;
  localparam logic [1:0] EM_BAD   = 2'd3;
  localparam logic signed [sddw_pkg::SPOS_W-1:0] FIRST_S =
    sddw_pkg::SPOS_W'(FIRST_POS);
  localparam logic [sddw_pkg::CNT_W-1:0] MAX_N = sddw_pkg::CNT_W'(sddw_pkg::MAX_RESULTS);

  logic [1:0]                             state_r, state_nxt;
  logic [sddw_pkg::BCD_W-1:0]             dig_r, dig_nxt;
  logic signed [sddw_pkg::SPOS_W-1:0]     pos_r, pos_nxt;
  logic signed [sddw_pkg::SPOS_W-1:0]     mpos_r, mpos_nxt;
  logic signed [sddw_pkg::SPOS_W-1:0]     limit_r, limit_nxt;
  logic [sddw_pkg::CNT_W-1:0]             n_r, n_nxt;
  logic                                   neg_r, neg_nxt;
  logic                                   st_r, st_nxt;
  logic                                   res_valid_r, res_valid_nxt;
  sddw_pkg::sddw_res_t                    res_r, res_nxt;

  logic                                   load;
  logic                                   rest_nz;
  logic signed [sddw_pkg::SPOS_W-1:0]     pos_a;
  logic signed [sddw_pkg::SPOS_W-1:0]     mpos;
  logic [sddw_pkg::CNT_W-1:0]             n_a;
  logic                                   cont;
  logic                                   minus_go;
  logic                                   fin;

  assign load      = !res_valid_r || res_ready;
  assign job_ready = (state_r == EM_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign rest_nz  = |dig_r[sddw_pkg::BCD_W-1:4];
  assign pos_a    = pos_r - 1'b1;
  assign n_a      = n_r + 1'b1;
  assign cont     = rest_nz && (pos_a >= FIRST_S) && (n_a < MAX_N);
  assign mpos     = (pos_a >= limit_r) ? (limit_r - 1'b1) : pos_a;
  assign minus_go = neg_r && (n_a < MAX_N) && (mpos > FIRST_S);
  assign fin      = !cont && !minus_go;

  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    pos_nxt       = pos_r;
    mpos_nxt      = mpos_r;
    limit_nxt     = limit_r;
    n_nxt         = n_r;
    neg_nxt       = neg_r;
    st_nxt        = st_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    unique case (state_r)
      EM_IDLE: begin
        if (job_valid) begin
          dig_nxt   = job.bcd;
          pos_nxt   = $signed({2'b00, job.units});
          limit_nxt = $signed({2'b00, job.units}) - $signed({3'b000, job.decs});
          n_nxt     = '0;
          neg_nxt   = job.neg;
          st_nxt    = 1'b0;
          state_nxt = job.bad ? EM_BAD : EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (load) begin
          res_valid_nxt          = 1'b1;
          res_nxt.write_valid    = 1'b1;
          res_nxt.digit_position = pos_r[sddw_pkg::POS_W-1:0];
          res_nxt.symbol         = {4'b0000, dig_r[3:0]};
          res_nxt.status         = fin && rest_nz;
          res_nxt.last           = fin;
          dig_nxt  = {4'b0000, dig_r[sddw_pkg::BCD_W-1:4]};
          pos_nxt  = pos_a;
          n_nxt    = n_a;
          mpos_nxt = mpos;
          st_nxt   = rest_nz;
          if (cont) begin
            state_nxt = EM_DIGIT;
          end else if (minus_go) begin
            state_nxt = EM_MINUS;
          end else begin
            state_nxt = EM_IDLE;
          end
        end
      end
      EM_MINUS: begin
        if (load) begin
          res_valid_nxt          = 1'b1;
          res_nxt.write_valid    = 1'b1;
          res_nxt.digit_position = mpos_r[sddw_pkg::POS_W-1:0];
          res_nxt.symbol         = minus_code;
          res_nxt.status         = st_r;
          res_nxt.last           = 1'b1;
          state_nxt              = EM_IDLE;
        end
      end
      EM_BAD: begin
        if (load) begin
          res_valid_nxt          = 1'b1;
          res_nxt.write_valid    = 1'b0;
          res_nxt.digit_position = '0;
          res_nxt.symbol         = '0;
          res_nxt.status         = 1'b1;
          res_nxt.last           = 1'b1;
          state_nxt              = EM_IDLE;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
    dig_r   <= dig_nxt;
    pos_r   <= pos_nxt;
    mpos_r  <= mpos_nxt;
    limit_r <= limit_nxt;
    n_r     <= n_nxt;
    neg_r   <= neg_nxt;
    st_r    <= st_nxt;
    res_r   <= res_nxt;
  end

endmodule
